// ----- sv/httptok_pkg.sv -----
// Package: shared types, codes and the method spelling table of the HTTP tokenizer.
`timescale 1ns / 1ps
package httptok_pkg;

  // Parse phases
  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_ARGS    = 3'd2;
  localparam logic [2:0] PH_VERSION = 3'd3;
  localparam logic [2:0] PH_HEADERS = 3'd4;
  localparam logic [2:0] PH_ERROR   = 3'd7;

  // Token kinds
  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_PATH    = 3'd1;
  localparam logic [2:0] KIND_ARG     = 3'd2;
  localparam logic [2:0] KIND_VERSION = 3'd3;
  localparam logic [2:0] KIND_HEADER  = 3'd4;
  localparam logic [2:0] KIND_SEP     = 3'd5;
  localparam logic [2:0] KIND_IGNORED = 3'd6;

  // Method codes
  localparam logic [2:0] METH_MATCHING = 3'd0;
  localparam logic [2:0] METH_GET      = 3'd1;
  localparam logic [2:0] METH_POST     = 3'd2;
  localparam logic [2:0] METH_PUT      = 3'd3;
  localparam logic [2:0] METH_INVALID  = 3'd4;

  // Parse status codes
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned OFFSET_W   = 16;
  localparam int unsigned ARG_NUM_W  = 4;
  localparam int unsigned HDR_NUM_W  = 5;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;
  localparam logic [2:0] METHOD_IDX_MAX = 3'd4;
  localparam logic [2:0] CANDS_ALL      = 3'b111;

  // Per-byte state other than the counters
  typedef struct packed {
    logic [2:0]          phase;
    logic [2:0]          method_index;
    logic [2:0]          method_cands;
    logic [OFFSET_W-1:0] offset;
    logic                start_pending;
  } state_t;

  // One result beat
  typedef struct packed {
    logic [OFFSET_W-1:0]  byte_offset;
    logic [2:0]           token_kind;
    logic                 token_start;
    logic [ARG_NUM_W-1:0] arg_number;
    logic [HDR_NUM_W-1:0] header_number;
    logic [2:0]           method_code;
    logic [1:0]           parse_status;
    logic                 token_dropped;
  } result_t;

  // Spelling of GET, POST and PUT followed by a space; zero past the end
  function automatic logic [7:0] method_char(input logic [1:0] cand, input logic [2:0] idx);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (cand)
      2'd0: begin
        unique case (idx)
          3'd0:    ch = 8'h47; // G
          3'd1:    ch = 8'h45; // E
          3'd2:    ch = 8'h54; // T
          3'd3:    ch = CH_SPACE;
          default: ch = CH_NUL;
        endcase
      end
      2'd1: begin
        unique case (idx)
          3'd0:    ch = 8'h50; // P
          3'd1:    ch = 8'h4F; // O
          3'd2:    ch = 8'h53; // S
          3'd3:    ch = 8'h54; // T
          3'd4:    ch = CH_SPACE;
          default: ch = CH_NUL;
        endcase
      end
      2'd2: begin
        unique case (idx)
          3'd0:    ch = 8'h50; // P
          3'd1:    ch = 8'h55; // U
          3'd2:    ch = 8'h54; // T
          3'd3:    ch = CH_SPACE;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Method code from a one-hot candidate set
  function automatic logic [2:0] method_of(input logic [2:0] cands);
    logic [2:0] code;
    unique case (cands)
      3'b001:  code = METH_GET;
      3'b010:  code = METH_POST;
      3'b100:  code = METH_PUT;
      default: code = METH_MATCHING;
    endcase
    return code;
  endfunction

  function automatic logic is_term(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

// ----- sv/httptok_if.sv -----
// Interfaces: byte input channel and result channel of the HTTP tokenizer.
`timescale 1ns / 1ps
interface httptok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface httptok_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] byte_offset;
  logic [2:0]  token_kind;
  logic        token_start;
  logic [3:0]  arg_number;
  logic [4:0]  header_number;
  logic [2:0]  method_code;
  logic [1:0]  parse_status;
  logic        token_dropped;

  modport source (output valid, output byte_offset, output token_kind, output token_start,
                  output arg_number, output header_number, output method_code,
                  output parse_status, output token_dropped, input ready);
  modport sink   (input valid, input byte_offset, input token_kind, input token_start,
                  input arg_number, input header_number, input method_code,
                  input parse_status, input token_dropped, output ready);
endinterface

// ----- sv/httptok_step.sv -----
// Next-state and result logic for one request byte.
`timescale 1ns / 1ps
module httptok_step #(
  parameter int unsigned MAX_ARGS    = 8,
  parameter int unsigned MAX_HEADERS = 16,
  parameter int unsigned ARG_W       = $clog2(MAX_ARGS + 1),
  parameter int unsigned HDR_W       = $clog2(MAX_HEADERS + 1)
) (
  input  logic [7:0]            char_byte_i,
  input  httptok_pkg::state_t   state_i,
  input  logic [ARG_W-1:0]      arg_count_i,
  input  logic [HDR_W-1:0]      hdr_count_i,
  output httptok_pkg::state_t   state_o,
  output logic [ARG_W-1:0]      arg_count_o,
  output logic [HDR_W-1:0]      hdr_count_o,
  output httptok_pkg::result_t  result_o
);
  import httptok_pkg::*;

  localparam logic [ARG_W-1:0] ArgMax = ARG_W'(MAX_ARGS);
  localparam logic [HDR_W-1:0] HdrMax = HDR_W'(MAX_HEADERS);

  logic [2:0] idx;
  logic [2:0] next_cands;
  logic [2:0] kind;
  logic       start;
  logic       dropped;
  logic [1:0] status;
  logic [2:0] mcode;

  // Clamp the method index and match the byte against each live candidate
  assign idx = (state_i.method_index < 3'd5) ? state_i.method_index : METHOD_IDX_MAX;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      next_cands[c] = state_i.method_cands[c] && (method_char(2'(c), idx) == char_byte_i);
    end
  end

  // Advance the parser by one byte
  always_comb begin
    state_o     = state_i;
    arg_count_o = arg_count_i;
    hdr_count_o = hdr_count_i;
    kind        = KIND_IGNORED;
    start       = 1'b0;
    dropped     = 1'b0;
    status      = ST_BUSY;

    if (state_i.phase == PH_METHOD) begin
      mcode = METH_MATCHING;
    end else if (state_i.phase == PH_PATH || state_i.phase == PH_ARGS ||
                 state_i.phase == PH_VERSION || state_i.phase == PH_HEADERS) begin
      mcode = method_of(state_i.method_cands);
    end else begin
      mcode = METH_INVALID;
    end

    if (char_byte_i == CH_NUL) begin
      // End of request: report, then rearm
      kind = KIND_SEP;
      if (state_i.phase == PH_VERSION || state_i.phase == PH_HEADERS) begin
        status = ST_OK;
      end else begin
        status = ST_ERROR;
        mcode  = METH_INVALID;
      end
      state_o.phase         = PH_METHOD;
      state_o.method_index  = '0;
      state_o.method_cands  = CANDS_ALL;
      state_o.offset        = '0;
      state_o.start_pending = 1'b0;
      arg_count_o           = '0;
      hdr_count_o           = '0;
    end else begin
      if (state_i.offset != OFFSET_MAX) state_o.offset = state_i.offset + 1'b1;

      unique case (state_i.phase)
        PH_METHOD: begin
          if (next_cands == 3'b000) begin
            state_o.phase = PH_ERROR;
            kind          = KIND_IGNORED;
            status        = ST_ERROR;
            mcode         = METH_INVALID;
          end else if (char_byte_i == CH_SPACE) begin
            state_o.method_cands  = next_cands;
            state_o.phase         = PH_PATH;
            state_o.start_pending = 1'b1;
            kind                  = KIND_SEP;
            mcode                 = method_of(next_cands);
          end else begin
            state_o.method_cands = next_cands;
            if (state_i.method_index < METHOD_IDX_MAX) begin
              state_o.method_index = state_i.method_index + 1'b1;
            end
            kind = KIND_METHOD;
          end
        end
        PH_PATH: begin
          if (is_term(char_byte_i)) begin
            kind                  = KIND_SEP;
            state_o.start_pending = 1'b0;
            state_o.phase         = PH_VERSION;
          end else if (char_byte_i == CH_QMARK) begin
            kind                  = KIND_SEP;
            state_o.start_pending = 1'b1;
            state_o.phase         = PH_ARGS;
          end else begin
            kind                  = KIND_PATH;
            start                 = state_i.start_pending;
            state_o.start_pending = 1'b0;
          end
        end
        PH_ARGS: begin
          if (is_term(char_byte_i)) begin
            kind                  = KIND_SEP;
            state_o.start_pending = 1'b0;
            state_o.phase         = PH_VERSION;
          end else if (char_byte_i == CH_AMP) begin
            kind                  = KIND_SEP;
            state_o.start_pending = 1'b1;
          end else begin
            kind = KIND_ARG;
            if (state_i.start_pending) begin
              if (arg_count_i < ArgMax) begin
                arg_count_o = arg_count_i + 1'b1;
                start       = 1'b1;
              end else begin
                dropped = 1'b1;
              end
            end
            state_o.start_pending = 1'b0;
          end
        end
        PH_VERSION: begin
          if (is_term(char_byte_i)) begin
            kind                  = KIND_SEP;
            state_o.phase         = PH_HEADERS;
            state_o.start_pending = 1'b1;
          end else begin
            kind = KIND_VERSION;
          end
        end
        PH_HEADERS: begin
          if (char_byte_i == CH_CR || char_byte_i == CH_LF) begin
            kind                  = KIND_SEP;
            state_o.start_pending = 1'b1;
          end else begin
            kind = KIND_HEADER;
            if (state_i.start_pending) begin
              if (hdr_count_i < HdrMax) begin
                hdr_count_o = hdr_count_i + 1'b1;
                start       = 1'b1;
              end else begin
                dropped = 1'b1;
              end
            end
            state_o.start_pending = 1'b0;
          end
        end
        default: begin
          state_o.phase = PH_ERROR;
          kind          = KIND_IGNORED;
          status        = ST_ERROR;
          mcode         = METH_INVALID;
        end
      endcase
    end
  end

  // Pack the result; the end byte shows the counts before rearming
  always_comb begin
    result_o.byte_offset   = state_i.offset;
    result_o.token_kind    = kind;
    result_o.token_start   = start;
    result_o.method_code   = mcode;
    result_o.parse_status  = status;
    result_o.token_dropped = dropped;
    if (char_byte_i == CH_NUL) begin
      result_o.arg_number    = ARG_NUM_W'(arg_count_i);
      result_o.header_number = HDR_NUM_W'(hdr_count_i);
    end else begin
      result_o.arg_number    = ARG_NUM_W'(arg_count_o);
      result_o.header_number = HDR_NUM_W'(hdr_count_o);
    end
  end

endmodule

// ----- sv/http_request_tokenizer.sv -----
// The result beat of an accepted byte is loaded into the output register.
// One byte per cycle unless the output stalls; parser state advances on each accepted byte.
// A byte is taken whenever the output register is empty or its beat leaves in the same cycle.
// Reset (rst_ni low, asynchronous) clears the output valid flag and returns the parser
// to method matching with zero counters and zero offset.
`timescale 1ns / 1ps
module http_request_tokenizer #(
  parameter int unsigned MAX_ARGS    = 8,
  parameter int unsigned MAX_HEADERS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  httptok_in_if.sink            in_i,
  httptok_out_if.source         out_o
);
  import httptok_pkg::*;

  localparam int unsigned ArgW = $clog2(MAX_ARGS + 1);
  localparam int unsigned HdrW = $clog2(MAX_HEADERS + 1);

  state_t            state_q, state_d;
  logic [ArgW-1:0]   arg_q, arg_d;
  logic [HdrW-1:0]   hdr_q, hdr_d;
  result_t           res_q, res_d;
  logic              out_vld_q;
  logic              take;

  // Accept a byte while the result register can drain
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;

  httptok_step #(
    .MAX_ARGS    (MAX_ARGS),
    .MAX_HEADERS (MAX_HEADERS),
    .ARG_W       (ArgW),
    .HDR_W       (HdrW)
  ) u_step (
    .char_byte_i (in_i.char_byte),
    .state_i     (state_q),
    .arg_count_i (arg_q),
    .hdr_count_i (hdr_q),
    .state_o     (state_d),
    .arg_count_o (arg_d),
    .hdr_count_o (hdr_d),
    .result_o    (res_d)
  );

  // Parser state: advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_METHOD;
      state_q.method_index  <= '0;
      state_q.method_cands  <= CANDS_ALL;
      state_q.offset        <= '0;
      state_q.start_pending <= 1'b0;
      arg_q                 <= '0;
      hdr_q                 <= '0;
    end else if (take) begin
      state_q <= state_d;
      arg_q   <= arg_d;
      hdr_q   <= hdr_d;
    end
  end

  // Output valid: set on a new byte, clear when the beat leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result payload: load with each accepted byte
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.byte_offset   = res_q.byte_offset;
  assign out_o.token_kind    = res_q.token_kind;
  assign out_o.token_start   = res_q.token_start;
  assign out_o.arg_number    = res_q.arg_number;
  assign out_o.header_number = res_q.header_number;
  assign out_o.method_code   = res_q.method_code;
  assign out_o.parse_status  = res_q.parse_status;
  assign out_o.token_dropped = res_q.token_dropped;

endmodule

// ----- tb/httptok_token_check.sv -----
// Checker: predicts every result beat of the HTTP request tokenizer and compares it with the DUT.
`timescale 1ns / 1ps
module httptok_token_check #(
  parameter int unsigned MAX_ARGS    = 8,
  parameter int unsigned MAX_HEADERS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  httptok_in_if  in_i,
  httptok_out_if out_i,
  output int     fail_count_o,
  output int     pending_o
);
  import httptok_pkg::*;

  // Parser state as seen by the predictor
  logic [2:0]          phase_q;
  logic [2:0]          midx_q;
  logic [2:0]          cands_q;
  logic [ARG_NUM_W-1:0] args_q;
  logic [HDR_NUM_W-1:0] hdrs_q;
  logic [OFFSET_W-1:0] offs_q;
  logic                pend_q;

  result_t expected_tokens[$];
  int      fail_total;

  assign fail_count_o = fail_total;

  // Letter expected at position pos of method word c; zero past the end
  function automatic logic [7:0] method_letter(input int c, input int unsigned pos);
    string word;
    case (c)
      0:       word = "GET ";
      1:       word = "POST ";
      default: word = "PUT ";
    endcase
    return (pos < word.len()) ? word[pos] : CH_NUL;
  endfunction

  // Decode a candidate set to a method code once exactly one remains
  function automatic logic [2:0] method_from_cands(input logic [2:0] cands);
    case (cands)
      3'b001:  return METH_GET;
      3'b010:  return METH_POST;
      3'b100:  return METH_PUT;
      default: return METH_MATCHING;
    endcase
  endfunction

  function automatic logic ends_field(input logic [7:0] b);
    return b == CH_SPACE || b == CH_CR || b == CH_LF;
  endfunction

  task automatic rearm_parser();
    phase_q = PH_METHOD;
    midx_q  = '0;
    cands_q = 3'b111;
    args_q  = '0;
    hdrs_q  = '0;
    offs_q  = '0;
    pend_q  = 1'b0;
  endtask

  // Advance the parser by one byte and build the beat it must produce
  task automatic tokenize_byte(input logic [7:0] b, output result_t r);
    logic [2:0]  viable;
    int unsigned pos;
    r = '0;
    r.byte_offset  = offs_q;
    r.token_kind   = KIND_IGNORED;
    r.parse_status = ST_BUSY;
    if (phase_q == PH_METHOD) begin
      r.method_code = METH_MATCHING;
    end else if (phase_q >= PH_PATH && phase_q <= PH_HEADERS) begin
      r.method_code = method_from_cands(cands_q);
    end else begin
      r.method_code = METH_INVALID;
    end

    if (b == CH_NUL) begin
      // End of request: report counts as they stand, then rearm
      r.token_kind    = KIND_SEP;
      r.arg_number    = args_q;
      r.header_number = hdrs_q;
      if (phase_q == PH_VERSION || phase_q == PH_HEADERS) begin
        r.parse_status = ST_OK;
      end else begin
        r.parse_status = ST_ERROR;
        r.method_code  = METH_INVALID;
      end
      rearm_parser();
    end else begin
      if (offs_q != '1) offs_q = offs_q + 1'b1;
      case (phase_q)
        PH_METHOD: begin
          pos    = (midx_q < 3'd5) ? midx_q : 4;
          viable = '0;
          for (int c = 0; c < 3; c++) begin
            if (cands_q[c] && method_letter(c, pos) == b) viable[c] = 1'b1;
          end
          if (viable == '0) begin
            phase_q        = PH_ERROR;
            r.parse_status = ST_ERROR;
            r.method_code  = METH_INVALID;
          end else if (b == CH_SPACE) begin
            cands_q       = viable;
            phase_q       = PH_PATH;
            pend_q        = 1'b1;
            r.token_kind  = KIND_SEP;
            r.method_code = method_from_cands(viable);
          end else begin
            cands_q = viable;
            if (midx_q < 3'd4) midx_q = midx_q + 1'b1;
            r.token_kind = KIND_METHOD;
          end
        end
        PH_PATH: begin
          if (ends_field(b)) begin
            r.token_kind = KIND_SEP;
            pend_q       = 1'b0;
            phase_q      = PH_VERSION;
          end else if (b == CH_QMARK) begin
            r.token_kind = KIND_SEP;
            pend_q       = 1'b1;
            phase_q      = PH_ARGS;
          end else begin
            r.token_kind  = KIND_PATH;
            r.token_start = pend_q;
            pend_q        = 1'b0;
          end
        end
        PH_ARGS: begin
          if (ends_field(b)) begin
            r.token_kind = KIND_SEP;
            pend_q       = 1'b0;
            phase_q      = PH_VERSION;
          end else if (b == CH_AMP) begin
            r.token_kind = KIND_SEP;
            pend_q       = 1'b1;
          end else begin
            r.token_kind = KIND_ARG;
            if (pend_q) begin
              if (args_q < MAX_ARGS) begin
                args_q        = args_q + 1'b1;
                r.token_start = 1'b1;
              end else begin
                r.token_dropped = 1'b1;
              end
            end
            pend_q = 1'b0;
          end
        end
        PH_VERSION: begin
          if (ends_field(b)) begin
            r.token_kind = KIND_SEP;
            phase_q      = PH_HEADERS;
            pend_q       = 1'b1;
          end else begin
            r.token_kind = KIND_VERSION;
          end
        end
        PH_HEADERS: begin
          if (b == CH_CR || b == CH_LF) begin
            r.token_kind = KIND_SEP;
            pend_q       = 1'b1;
          end else begin
            r.token_kind = KIND_HEADER;
            if (pend_q) begin
              if (hdrs_q < MAX_HEADERS) begin
                hdrs_q        = hdrs_q + 1'b1;
                r.token_start = 1'b1;
              end else begin
                r.token_dropped = 1'b1;
              end
            end
            pend_q = 1'b0;
          end
        end
        default: begin
          phase_q        = PH_ERROR;
          r.parse_status = ST_ERROR;
          r.method_code  = METH_INVALID;
        end
      endcase
      r.arg_number    = args_q;
      r.header_number = hdrs_q;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  initial rearm_parser();

  // Predict on every input beat, compare on every output beat
  always @(posedge clk_i) begin
    result_t want;
    result_t seen;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) begin
        tokenize_byte(in_i.char_byte, want);
        expected_tokens.push_back(want);
      end
      if (out_i.valid && out_i.ready) begin
        seen.byte_offset   = out_i.byte_offset;
        seen.token_kind    = out_i.token_kind;
        seen.token_start   = out_i.token_start;
        seen.arg_number    = out_i.arg_number;
        seen.header_number = out_i.header_number;
        seen.method_code   = out_i.method_code;
        seen.parse_status  = out_i.parse_status;
        seen.token_dropped = out_i.token_dropped;
        if (expected_tokens.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, actual %h",
                   $time, seen);
          fail_total++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("byte_offset", want.byte_offset, seen.byte_offset);
          check_field("token_kind", want.token_kind, seen.token_kind);
          check_field("token_start", want.token_start, seen.token_start);
          check_field("arg_number", want.arg_number, seen.arg_number);
          check_field("header_number", want.header_number, seen.header_number);
          check_field("method_code", want.method_code, seen.method_code);
          check_field("parse_status", want.parse_status, seen.parse_status);
          check_field("token_dropped", want.token_dropped, seen.token_dropped);
        end
      end
      pending_o <= expected_tokens.size();
    end
  end

endmodule

// ----- tb/http_request_tokenizer_tb.sv -----
// Testbench top: clock, reset, request stimulus, output back-pressure, watchdog and verdict.
`timescale 1ns / 1ps
module http_request_tokenizer_tb;
  import httptok_pkg::*;

  localparam int unsigned MAX_ARGS    = 8;
  localparam int unsigned MAX_HEADERS = 16;
  localparam int unsigned QUIET_LIMIT = 1000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm;
  int   fails;
  int   pending;
  int unsigned sent;
  int unsigned quiet_cycles;

  httptok_in_if  in_if ();
  httptok_out_if out_if ();

  http_request_tokenizer #(
    .MAX_ARGS   (MAX_ARGS),
    .MAX_HEADERS(MAX_HEADERS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  httptok_token_check #(
    .MAX_ARGS   (MAX_ARGS),
    .MAX_HEADERS(MAX_HEADERS)
  ) u_token_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_i       (out_if),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  always #10 clk_i = ~clk_i;

  // Stall the result side at random, except in the calm stretch
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= rst_ni && (calm || $urandom_range(99) >= 17);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one byte, idling first at random, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 17) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold off the input until every expected beat has come out
  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly letters and slashes, some marks, some arbitrary bytes
  function automatic logic [7:0] content_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 8'(8'h61 + $urandom_range(25));
    if (pick < 80) return 8'h2F;
    if (pick < 85) return CH_QMARK;
    if (pick < 88) return CH_AMP;
    return 8'($urandom_range(255, 1));
  endfunction

  function automatic logic [7:0] field_end();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] line_break();
    return $urandom_range(1) ? CH_CR : CH_LF;
  endfunction

  // One request: well formed with random content most of the time, else noise or broken
  task automatic send_request();
    int unsigned style;
    int unsigned n;
    int unsigned len;
    string       word;
    style = $urandom_range(99);
    if (style < 8) begin
      n = $urandom_range(20, 1);
      repeat (n) send_byte(8'($urandom_range(255, 1)));
      send_byte(CH_NUL);
    end else begin
      case ($urandom_range(2))
        0:       word = "GET ";
        1:       word = "POST ";
        default: word = "PUT ";
      endcase
      if (style < 11) begin
        // cut off while the method is still matching
        send_text(word.substr(0, $urandom_range(word.len() - 2)));
        send_byte(CH_NUL);
      end else begin
        if (style < 16) word[$urandom_range(word.len() - 1)] = 8'($urandom_range(255, 1));
        send_text(word);
        repeat ($urandom_range(6)) send_byte(content_byte());
        if ($urandom_range(99) < 60) begin
          send_byte(CH_QMARK);
          n = ($urandom_range(99) < 12) ? $urandom_range(11, 8) : $urandom_range(4);
          for (int k = 0; k < n; k++) begin
            if (k > 0) send_byte(CH_AMP);
            repeat ($urandom_range(3)) send_byte(content_byte());
          end
        end
        if (style < 21) begin
          send_byte(CH_NUL);
        end else begin
          send_byte(field_end());
          if ($urandom_range(99) < 30) send_byte(line_break());
          if ($urandom_range(1)) send_text("HTTP/1.1");
          else repeat ($urandom_range(8)) send_byte(content_byte());
          send_byte(field_end());
          n = ($urandom_range(99) < 12) ? $urandom_range(19, 15) : $urandom_range(4);
          repeat (n) begin
            if ($urandom_range(99) < 10) send_byte(line_break());
            len = $urandom_range(6, 1);
            repeat (len) send_byte(content_byte());
            case ($urandom_range(3))
              0: begin
                send_byte(CH_CR);
                send_byte(CH_LF);
              end
              1: send_byte(CH_LF);
              2: send_byte(CH_CR);
              default: begin
                send_byte(CH_CR);
                send_byte(CH_CR);
                send_byte(CH_LF);
              end
            endcase
          end
          send_byte(CH_NUL);
        end
      end
    end
  endtask

  initial begin
    int unsigned req;
    in_if.valid     <= 1'b0;
    in_if.char_byte <= CH_NUL;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty argument, full request with high bytes and paired breaks
    send_text("POST /");
    send_byte(8'hFF);
    send_text("?&a V");
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_text("h");
    send_byte(8'h80);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_NUL);
    // zero during method matching, then a method mismatch
    send_byte(CH_NUL);
    send_text("GET?");
    send_byte(CH_NUL);

    // Random requests
    for (req = 0; sent < 720; req++) begin
      if (req == 15) calm = 1'b1;
      if (req == 35) calm = 1'b0;
      if (req == 10 || $urandom_range(99) < 4) wait_all_results();
      send_request();
    end

    wait_all_results();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- http_request_tokenizer.f -----
sv/httptok_pkg.sv
sv/httptok_if.sv
sv/httptok_step.sv
sv/http_request_tokenizer.sv
tb/httptok_token_check.sv
tb/http_request_tokenizer_tb.sv
